// File: src/bloom_pkg.sv
package bloom_pkg;

  localparam int MAX_CELLS_DEF   = 65536;
  localparam int MAX_HASHES_DEF  = 16;
  localparam int DIGEST_BITS_DEF = 64;

  localparam int CELL_CNT_W = 17;
  localparam int HASH_CNT_W = 5;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int DIGEST_W   = 64;
  localparam int POS_W      = 4;
  localparam int ACTION_W   = 2;

  localparam logic [CELL_CNT_W-1:0] CELL_CNT_RST = 17'd65536;
  localparam logic [HASH_CNT_W-1:0] HASH_CNT_RST = 5'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_MODE = 2'd2;

  typedef enum logic [1:0] {
    ACT_ADD,
    ACT_LOOKUP,
    ACT_REMOVE,
    ACT_CLEAR
  } action_e;

  // operand selection of the shared divider
  typedef enum logic [2:0] {
    OP_PART,
    OP_POS,
    OP_DMOD,
    OP_FIN,
    OP_MOD
  } div_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MUL,
    ST_ACCESS,
    ST_READ
  } state_e;

  typedef struct packed {
    logic    idle;
    logic    load_item;
    logic    div_start;
    div_op_e div_op;
    logic    div_latch;
    logic    mul;
    logic    ram_write;
    logic    ram_read;
    logic    clr_step;
    logic    lookup_update;
  } cmd_t;

  typedef struct packed {
    logic    div_done;
    logic    partition;
    logic    clr_last;
    action_e action;
    logic    last;
    logic    out_busy;
  } status_t;

endpackage

// File: src/bloom_ram.sv
module bloom_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bloom_ctrl.sv
module bloom_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [bloom_pkg::ACTION_W-1:0] in_action_i,
  input  bloom_pkg::status_t            status_i,
  output bloom_pkg::cmd_t               cmd_o
);
  import bloom_pkg::*;

  state_e  state_q, state_d;
  div_op_e op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      op_q    <= OP_MOD;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    cmd_o         = '0;
    cmd_o.div_op  = op_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.idle = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          if (action_e'(in_action_i) == ACT_CLEAR) begin
            state_d = ST_CLEAR;
          end else if (status_i.partition) begin
            op_d    = OP_PART;
            state_d = ST_START;
          end else begin
            op_d    = OP_MOD;
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.div_latch = 1'b1;
          case (op_q)
            OP_PART: begin
              op_d    = OP_POS;
              state_d = ST_START;
            end
            OP_POS: begin
              op_d    = OP_DMOD;
              state_d = ST_START;
            end
            OP_DMOD: begin
              state_d = ST_MUL;
            end
            default: begin
              state_d = ST_ACCESS;
            end
          endcase
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        op_d      = OP_FIN;
        state_d   = ST_START;
      end
      ST_ACCESS: begin
        if (status_i.action == ACT_LOOKUP) begin
          cmd_o.ram_read = 1'b1;
          state_d        = ST_READ;
        end else begin
          cmd_o.ram_write = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_READ: begin
        // hold while the previous answer still waits downstream
        if (!(status_i.last && status_i.out_busy)) begin
          cmd_o.lookup_update = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/bloom_dpath.sv
module bloom_dpath #(
  parameter int MAX_CELLS   = bloom_pkg::MAX_CELLS_DEF,
  parameter int MAX_HASHES  = bloom_pkg::MAX_HASHES_DEF,
  parameter int DIGEST_BITS = bloom_pkg::DIGEST_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bloom_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bloom_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [bloom_pkg::ACTION_W-1:0]   action_i,
  input  logic [bloom_pkg::DIGEST_W-1:0]   digest_i,
  input  logic [bloom_pkg::POS_W-1:0]      digest_position_i,
  input  logic                            last_digest_i,
  input  logic                            out_stall_i,
  input  bloom_pkg::cmd_t                 cmd_i,
  output bloom_pkg::status_t              status_o,
  output logic                            out_valid_o,
  output logic                            present_o
);
  import bloom_pkg::*;

  localparam int CNT_W    = $clog2(MAX_CELLS + 1);
  localparam int ADDR_W   = $clog2(MAX_CELLS);
  localparam int HSH_W    = $clog2(MAX_HASHES + 1);
  localparam int PROD_W   = HSH_W + CNT_W;
  localparam int DIV_W    = (DIGEST_BITS > PROD_W) ? DIGEST_BITS : PROD_W;
  localparam int DSR_W    = (CNT_W > HSH_W) ? CNT_W : HSH_W;
  localparam int ITER_W   = $clog2(DIV_W + 1);

  // configuration
  logic [CELL_CNT_W-1:0] cell_count_q;
  logic [HASH_CNT_W-1:0] hash_count_q;
  logic                  partition_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q <= CELL_CNT_RST;
      hash_count_q <= HASH_CNT_RST;
      partition_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CELL_COUNT:     cell_count_q <= cfg_data_i[CELL_CNT_W-1:0];
        CFG_HASH_COUNT:     hash_count_q <= cfg_data_i[HASH_CNT_W-1:0];
        CFG_PARTITION_MODE: partition_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] eff_cells;
  logic [HSH_W-1:0] eff_hashes;
  logic [31:0]      cells_ext;
  logic [31:0]      hashes_ext;

  // clamp both counts into their legal ranges
  always_comb begin
    cells_ext  = 32'(cell_count_q);
    hashes_ext = 32'(hash_count_q);
    if (cells_ext == 32'd0) begin
      eff_cells = CNT_W'(1);
    end else if (cells_ext > 32'(MAX_CELLS)) begin
      eff_cells = CNT_W'(MAX_CELLS);
    end else begin
      eff_cells = CNT_W'(cells_ext);
    end
    if (hashes_ext == 32'd0) begin
      eff_hashes = HSH_W'(1);
    end else if (hashes_ext > 32'(MAX_HASHES)) begin
      eff_hashes = HSH_W'(MAX_HASHES);
    end else begin
      eff_hashes = HSH_W'(hashes_ext);
    end
  end

  // transaction registers
  action_e                act_q;
  logic [DIGEST_BITS-1:0] dig_q;
  logic [POS_W-1:0]       pos_in_q;
  logic                   last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      act_q    <= action_e'(action_i);
      dig_q    <= digest_i[DIGEST_BITS-1:0];
      pos_in_q <= digest_position_i;
      last_q   <= last_digest_i;
    end
  end

  // shared restoring divider, one quotient bit per cycle
  logic [DIV_W-1:0]  dvd_q;
  logic [DSR_W-1:0]  rem_q;
  logic [DSR_W-1:0]  dsr_q;
  logic [ITER_W-1:0] iter_q;
  logic              busy_q;
  logic [DIV_W-1:0]  ld_dvd;
  logic [DSR_W-1:0]  ld_dsr;
  logic [ITER_W-1:0] ld_iter;
  logic [DSR_W:0]    trial;
  logic              fits;
  logic              div_done;

  // intermediate address terms
  logic [CNT_W-1:0]  part_q;
  logic [HSH_W-1:0]  pos_q;
  logic [CNT_W-1:0]  dmod_q;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] fin_sum;
  logic [ADDR_W-1:0] addr_q;
  logic [CNT_W-1:0]  quot;

  assign fin_sum = prod_q + PROD_W'(dmod_q);
  assign quot    = dvd_q[CNT_W-1:0];

  // align the live dividend bits at the top so only they are iterated
  always_comb begin
    case (cmd_i.div_op)
      OP_PART: begin
        ld_dvd  = DIV_W'(eff_cells) << (DIV_W - CNT_W);
        ld_dsr  = DSR_W'(eff_hashes);
        ld_iter = ITER_W'(CNT_W);
      end
      OP_POS: begin
        ld_dvd  = DIV_W'(pos_in_q) << (DIV_W - POS_W);
        ld_dsr  = DSR_W'(eff_hashes);
        ld_iter = ITER_W'(POS_W);
      end
      OP_DMOD: begin
        ld_dvd  = DIV_W'(dig_q) << (DIV_W - DIGEST_BITS);
        ld_dsr  = DSR_W'(part_q);
        ld_iter = ITER_W'(DIGEST_BITS);
      end
      OP_FIN: begin
        ld_dvd  = DIV_W'(fin_sum) << (DIV_W - PROD_W);
        ld_dsr  = DSR_W'(eff_cells);
        ld_iter = ITER_W'(PROD_W);
      end
      default: begin
        ld_dvd  = DIV_W'(dig_q) << (DIV_W - DIGEST_BITS);
        ld_dsr  = DSR_W'(eff_cells);
        ld_iter = ITER_W'(DIGEST_BITS);
      end
    endcase
  end

  assign trial    = {rem_q, dvd_q[DIV_W-1]};
  assign fits     = trial >= {1'b0, dsr_q};
  assign div_done = busy_q && (iter_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      iter_q <= ld_iter;
    end else if (cmd_i.div_latch) begin
      busy_q <= 1'b0;
    end else if (busy_q && (iter_q != '0)) begin
      iter_q <= iter_q - ITER_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= ld_dvd;
      dsr_q <= ld_dsr;
      rem_q <= '0;
    end else if (busy_q && (iter_q != '0)) begin
      dvd_q <= {dvd_q[DIV_W-2:0], fits};
      rem_q <= fits ? DSR_W'(trial - {1'b0, dsr_q}) : DSR_W'(trial);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_latch) begin
      case (cmd_i.div_op)
        OP_PART: part_q <= (quot == '0) ? CNT_W'(1) : quot;
        OP_POS:  pos_q  <= rem_q[HSH_W-1:0];
        OP_DMOD: dmod_q <= rem_q[CNT_W-1:0];
        default: addr_q <= rem_q[ADDR_W-1:0];
      endcase
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(pos_q) * PROD_W'(part_q);
    end
  end

  // clearing sweep
  logic [ADDR_W-1:0] clr_cnt_q;
  logic              clr_last;

  assign clr_last = clr_cnt_q == ADDR_W'(MAX_CELLS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_last ? '0 : clr_cnt_q + ADDR_W'(1);
    end
  end

  // bit store
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [0:0]        ram_wdata;
  logic [0:0]        ram_rdata;

  assign ram_we    = cmd_i.ram_write || cmd_i.clr_step;
  assign ram_waddr = cmd_i.clr_step ? clr_cnt_q : addr_q;
  assign ram_wdata = cmd_i.clr_step ? 1'b0 : (act_q == ACT_ADD);

  bloom_ram #(
    .WIDTH (1),
    .DEPTH (MAX_CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.ram_read),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // lookup accumulation and result register
  logic all_set_q;
  logic all_set_new;
  logic out_valid_q;
  logic present_q;

  assign all_set_new = all_set_q & ram_rdata[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_set_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.lookup_update && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load_item && (action_e'(action_i) != ACT_LOOKUP)) begin
        all_set_q <= 1'b1;
      end else if (cmd_i.lookup_update) begin
        all_set_q <= last_q ? 1'b1 : all_set_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup_update && last_q) begin
      present_q <= all_set_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign present_o   = present_q;

  always_comb begin
    status_o           = '0;
    status_o.div_done  = div_done;
    status_o.partition = partition_q;
    status_o.clr_last  = clr_last;
    status_o.action    = act_q;
    status_o.last      = last_q;
    status_o.out_busy  = out_valid_q && out_stall_i;
  end

endmodule

// File: src/bloom_filter_bit_store.sv
// Plain mode: an add or remove is set by the shared one-bit-per-cycle divider for digest mod
// cell count; a lookup adds a read step.
// Partition mode adds the divisions for part size, position and final wrap, and a multiply,
// for each digest; a lookup again adds a read step.
// A clear and the release of reset sweep the whole bit store, input stalled.
// Reset: configuration returns to 65536 cells, 4 hashes, plain mode; no result pending.
module bloom_filter_bit_store #(
  parameter int MAX_CELLS   = bloom_pkg::MAX_CELLS_DEF,
  parameter int MAX_HASHES  = bloom_pkg::MAX_HASHES_DEF,
  parameter int DIGEST_BITS = bloom_pkg::DIGEST_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bloom_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bloom_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bloom_pkg::ACTION_W-1:0]   action_i,
  input  logic [bloom_pkg::DIGEST_W-1:0]   digest_i,
  input  logic [bloom_pkg::POS_W-1:0]      digest_position_i,
  input  logic                            last_digest_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            present_o
);
  import bloom_pkg::*;

  cmd_t    cmd;
  status_t status;

  bloom_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (action_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bloom_dpath #(
    .MAX_CELLS   (MAX_CELLS),
    .MAX_HASHES  (MAX_HASHES),
    .DIGEST_BITS (DIGEST_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .action_i          (action_i),
    .digest_i          (digest_i),
    .digest_position_i (digest_position_i),
    .last_digest_i     (last_digest_i),
    .out_stall_i       (out_stall_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .present_o         (present_o)
  );

  assign in_stall_o = ~cmd.idle;

endmodule

// File: src/bloom_chk.sv
module bloom_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic present_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(present_o))
  else $error("result changed or dropped under stall");

  // one transaction in flight: the block is busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
  else $error("second transaction accepted back to back");

  // a result only comes out of work in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
  else $error("result raised while idle");

  // the clearing sweep follows reset release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o && !out_valid_o)
  else $error("input taken before the store was cleared");

endmodule

bind bloom_filter_bit_store bloom_chk u_chk (.*);

// File: dv/bloom_filter_bit_store_tb.sv
module bloom_filter_bit_store_tb;
  import bloom_pkg::*;

  localparam int     DRAIN_CYCLES = 200;
  localparam int     PHASE_ITEMS  = 150;
  localparam int     N_SETTINGS   = 12;
  localparam longint RUN_LIMIT    = 64'd40_000_000;

  // Tracks the filter bits and the running lookup AND, queues the answers owed.
  class bit_store_tracker;
    bit              cell_bits [MAX_CELLS_DEF];
    bit              all_hit;
    logic [16:0]     cell_count;
    logic [4:0]      hash_count;
    bit              partitioned;
    bit              present_due [$];
    int              mismatches;

    function new();
      foreach (cell_bits[i]) cell_bits[i] = 1'b0;
      all_hit     = 1'b1;
      cell_count  = CELL_CNT_RST;
      hash_count  = HASH_CNT_RST;
      partitioned = 1'b0;
      mismatches  = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CELL_COUNT:     cell_count = data[16:0];
        CFG_HASH_COUNT:     hash_count = data[4:0];
        CFG_PARTITION_MODE: partitioned = data[0];
        default: ;
      endcase
    endfunction

    function longint unsigned used_cells();
      if (cell_count == 0) return 1;
      if (cell_count > MAX_CELLS_DEF) return MAX_CELLS_DEF;
      return cell_count;
    endfunction

    function int object_len();
      if (hash_count == 0) return 1;
      if (hash_count > MAX_HASHES_DEF) return MAX_HASHES_DEF;
      return hash_count;
    endfunction

    function int unsigned cell_of(logic [63:0] d, logic [3:0] pos);
      longint unsigned cells;
      longint unsigned hashes;
      longint unsigned part;
      longint unsigned slot;
      cells = used_cells();
      if (!partitioned) return int'(d % cells);
      hashes = object_len();
      part   = cells / hashes;
      if (part == 0) part = 1;
      slot = longint'(pos) % hashes;
      return int'((slot * part + d % part) % cells);
    endfunction

    function void note_digest(action_e act, logic [63:0] d, logic [3:0] pos, logic last);
      case (act)
        ACT_ADD: begin
          cell_bits[cell_of(d, pos)] = 1'b1;
          all_hit = 1'b1;
        end
        ACT_LOOKUP: begin
          if (!cell_bits[cell_of(d, pos)]) all_hit = 1'b0;
          if (last) begin
            present_due.push_back(all_hit);
            all_hit = 1'b1;
          end
        end
        ACT_REMOVE: begin
          cell_bits[cell_of(d, pos)] = 1'b0;
          all_hit = 1'b1;
        end
        default: begin
          foreach (cell_bits[i]) cell_bits[i] = 1'b0;
          all_hit = 1'b1;
        end
      endcase
    endfunction

    task check_present(logic got);
      bit want;
      if (present_due.size() == 0) begin
        report($sformatf("present=%b with no lookup pending", got));
      end else begin
        want = present_due.pop_front();
        if (got !== want) report($sformatf("present=%b, want %b", got, want));
      end
    endtask

    function int pending();
      return present_due.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [ACTION_W-1:0]   action_i;
  logic [DIGEST_W-1:0]   digest_i;
  logic [POS_W-1:0]      digest_position_i;
  logic                  last_digest_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  present_o;

  bit_store_tracker tracker = new();

  int          items_sent;
  int          burst_left;
  int          clears_left;
  logic [63:0] kept_digests [9][16];
  int          kept_n;
  logic [15:0] sink_tick = '0;
  logic [1:0]  sink_mode = 2'd0;

  logic [16:0] cfg_cells [N_SETTINGS] = '{17'd65536, 17'h1FFFF, 17'd0, 17'd1, 17'd7, 17'd100,
                                          17'd65536, 17'd2048, 17'd13, 17'd65535, 17'd1, 17'd1};
  logic [4:0]  cfg_hashes [N_SETTINGS] = '{5'd4, 5'd16, 5'd0, 5'd31, 5'd3, 5'd16,
                                           5'd1, 5'd8, 5'd5, 5'd7, 5'd1, 5'd1};
  logic        cfg_part [N_SETTINGS] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1,
                                         1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

  bloom_filter_bit_store dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .digest_i          (digest_i),
    .digest_position_i (digest_position_i),
    .last_digest_i     (last_digest_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .present_o         (present_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check each lookup answer, stall in regimes picked anew when sink_tick[7:0] wraps.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_present(present_o);
    sink_tick <= sink_tick + 16'd1;
    if (sink_tick[7:0] == 8'd0) sink_mode <= 2'($urandom_range(0, 3));
    case (sink_mode)
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= 1'($urandom_range(0, 1));
      2'd2:    out_stall_i <= (sink_tick[5:0] < 6'd40);
      default: out_stall_i <= ($urandom_range(0, 9) == 0);
    endcase
  end

  function automatic logic [63:0] rand_digest();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(0, 300));
      3:       return {1'b1, 31'($urandom), 32'($urandom)};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Sender pacing: bursts of back-to-back transactions, then a gap.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 15);
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 12);
    in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic send_item(action_e act, logic [63:0] d, logic [3:0] pos, logic last);
    in_valid_i        <= 1'b1;
    action_i          <= act;
    digest_i          <= d;
    digest_position_i <= pos;
    last_digest_i     <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_digest(act, d, pos, last);
    items_sent++;
    pace();
  endtask

  task automatic send_object(action_e act, int slot, int count, bit with_last);
    for (int i = 0; i < count; i++)
      send_item(act, kept_digests[slot][i], 4'(i), with_last && (i == count - 1));
  endtask

  task automatic fresh_object(int slot);
    for (int i = 0; i < 16; i++) kept_digests[slot][i] = rand_digest();
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  // Close with a lookup so its answer marks the block idle, then drain.
  task automatic settle();
    send_item(ACT_LOOKUP, rand_digest(), 4'd0, 1'b1);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random(int quota);
    int start;
    int pick;
    int h;
    int slot;
    start = items_sent;
    while (items_sent - start < quota) begin
      h    = tracker.object_len();
      pick = $urandom_range(0, 99);
      if (clears_left > 0 && $urandom_range(0, 399) == 0) begin
        clears_left--;
        send_item(ACT_CLEAR, rand_digest(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end else if (pick < 35) begin
        if (kept_n < 8) begin
          slot = kept_n;
          kept_n++;
        end else begin
          slot = $urandom_range(0, 7);
        end
        fresh_object(slot);
        send_object(ACT_ADD, slot, h, 1'b1);
      end else if (pick < 75) begin
        if ($urandom_range(0, 9) < 7) begin
          slot = $urandom_range(0, kept_n - 1);
        end else begin
          slot = 8;
          fresh_object(slot);
        end
        send_object(ACT_LOOKUP, slot, h, 1'b1);
      end else if (pick < 83) begin
        slot = $urandom_range(0, kept_n - 1);
        if ($urandom_range(0, 1) == 0) begin
          send_object(ACT_REMOVE, slot, h, 1'b1);
        end else begin
          pick = $urandom_range(0, h - 1);
          send_item(ACT_REMOVE, kept_digests[slot][pick], 4'(pick), 1'b1);
        end
      end else if (pick < 93) begin
        // abandon a lookup partway through
        slot = $urandom_range(0, kept_n - 1);
        send_object(ACT_LOOKUP, slot, (h > 1) ? $urandom_range(1, h - 1) : 1, 1'b0);
        send_item(action_e'($urandom_range(0, 2)), rand_digest(), 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)));
      end else begin
        send_item(action_e'($urandom_range(0, 2)), rand_digest(), 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : stimulus
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_index_i       <= '0;
    cfg_data_i        <= '0;
    in_valid_i        <= 1'b0;
    action_i          <= ACT_ADD;
    digest_i          <= '0;
    digest_position_i <= '0;
    last_digest_i     <= 1'b0;
    items_sent  = 0;
    burst_left  = 0;
    clears_left = 3;
    kept_n      = 1;
    cfg_cells[10]  = 17'($urandom_range(1, 65536));
    cfg_hashes[10] = 5'($urandom_range(1, 16));
    cfg_part[10]   = 1'($urandom_range(0, 1));
    cfg_cells[11]  = 17'($urandom_range(1, 512));
    cfg_hashes[11] = 5'($urandom_range(1, 16));
    cfg_part[11]   = 1'($urandom_range(0, 1));
    kept_digests[0][0] = 64'h0;
    kept_digests[0][1] = 64'hFFFF_FFFF_FFFF_FFFF;
    kept_digests[0][2] = 64'h8000_0000_0000_0000;
    kept_digests[0][3] = 64'h5555_5555_5555_5555;
    for (int i = 4; i < 16; i++) kept_digests[0][i] = rand_digest();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: 65536 cells, 4 hashes, plain addressing
    send_object(ACT_ADD, 0, 4, 1'b1);
    send_object(ACT_LOOKUP, 0, 4, 1'b1);
    send_item(ACT_LOOKUP, 64'h0000_0000_0001_2345, 4'd15, 1'b1);
    // an add in the middle of a lookup restarts the AND
    send_item(ACT_LOOKUP, 64'h1234, 4'd7, 1'b0);
    send_item(ACT_ADD, 64'hABCD, 4'd15, 1'b0);
    send_item(ACT_LOOKUP, kept_digests[0][1], 4'd0, 1'b1);
    send_item(ACT_REMOVE, kept_digests[0][3], 4'd3, 1'b1);
    send_object(ACT_LOOKUP, 0, 4, 1'b1);
    send_item(ACT_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
    send_item(ACT_LOOKUP, kept_digests[0][0], 4'd0, 1'b1);

    for (int p = 0; p < N_SETTINGS; p++) begin
      settle();
      set_reg(CFG_CELL_COUNT, cfg_cells[p]);
      set_reg(CFG_HASH_COUNT, CFG_DATA_W'(cfg_hashes[p]));
      set_reg(CFG_PARTITION_MODE, CFG_DATA_W'(cfg_part[p]));
      cfg_we_i <= 1'b0;
      run_random(PHASE_ITEMS);
    end

    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.pending() != 0) tracker.report("lookup answers still owed at end");
    if (tracker.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
